### rtl/core/kffd_pkg.sv
// shared types, codes and bit-gathering functions of the key-fob frame field decoder
// no dependencies; compiled first
package kffd_pkg;

  // protocol type codes
  typedef enum logic [1:0] {
    PROTO_NONE = 2'd0,
    PROTO_A    = 2'd1,
    PROTO_B    = 2'd2,
    PROTO_C    = 2'd3
  } proto_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROT,
    ST_FINISH
  } kffd_state_t;

  // controls from the sequencer to the datapath
  typedef struct packed {
    logic load;
    logic step;
    logic latch;
  } kffd_ctl_t;

  localparam int unsigned RotWidth  = 24;
  localparam int unsigned StepWidth = 9;
  localparam logic [StepWidth-1:0] RotBase = 9'd4;

  // low counter byte: inverted bits gathered from bytes 4..6
  function automatic logic [7:0] gather_lo(input logic [63:0] w);
    logic [7:0] b4, b5, b6;
    b4 = w[31:24];
    b5 = w[23:16];
    b6 = w[15:8];
    return ~{b5[7], b5[6], b6[1], b6[0], b5[1], b5[0], b4[7], b4[6]};
  endfunction

  // serial register seed: bytes 3, 1, 2
  function automatic logic [RotWidth-1:0] rot_seed(input logic [63:0] w);
    return {w[39:32], w[55:48], w[47:40]};
  endfunction

  // high counter byte from the rotated register and the key bytes
  function automatic logic [7:0] gather_hi(input logic [63:0] w,
                                           input logic [RotWidth-1:0] v);
    logic [7:0] b5, b6, b7, sh1, sh2, t1, t2;
    b5  = w[23:16];
    b6  = w[15:8];
    b7  = w[7:0];
    sh1 = {b7[3:0], b5[3], b5[2], b6[7], b6[6]};
    sh2 = {b6[5:2], b7[7:4]};
    t1  = v[15:8] ^ sh1;
    t2  = v[7:0] ^ sh2;
    return ~{t1[1], t1[0], t2[3], t2[2], t1[5], t1[4], t2[7], t2[6]};
  endfunction

endpackage

### rtl/core/kffd_in_if.sv
// input channel of the frame field decoder: valid, ready and frame payload
// no dependencies
interface kffd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  proto_type;
  logic [63:0] frame_word;
  logic [63:0] extra_word;

  modport source (output valid, output proto_type, output frame_word, output extra_word,
                  input ready);
  modport sink   (input valid, input proto_type, input frame_word, input extra_word,
                  output ready);
endinterface

### rtl/core/kffd_out_if.sv
// output channel of the frame field decoder: valid, ready and decoded fields
// no dependencies
interface kffd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] serial_id;
  logic [3:0]  button_code;
  logic        button_present;
  logic [15:0] counter_value;
  logic        counter_present;

  modport source (output valid, output serial_id, output button_code,
                  output button_present, output counter_value, output counter_present,
                  input ready);
  modport sink   (input valid, input serial_id, input button_code,
                  input button_present, input counter_value, input counter_present,
                  output ready);
endinterface

### rtl/core/kffd_rot_unit.sv
// shared rotate unit: 24-bit serial register rotated left one bit per step
// depends on kffd_pkg
module kffd_rot_unit (
  input  logic                         clk,
  input  kffd_pkg::kffd_ctl_t          ctl,
  input  logic [kffd_pkg::RotWidth-1:0] seed,
  output logic [kffd_pkg::RotWidth-1:0] value
);
  import kffd_pkg::*;

  logic [RotWidth-1:0] rot_reg;

  // load on accept, rotate by one on each step
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rot_reg <= seed;
    end else if (ctl.step) begin
      rot_reg <= {rot_reg[RotWidth-2:0], rot_reg[RotWidth-1]};
    end
  end

  assign value = rot_reg;
endmodule

### rtl/core/kffd_ctrl.sv
// sequencer: accepts an item, counts rotate steps, presents the result
// depends on kffd_pkg
module kffd_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          rot_needed,
  input  logic [kffd_pkg::StepWidth-1:0] rot_steps,
  input  logic                          out_ready,
  output logic                          in_ready,
  output logic                          out_valid,
  output kffd_pkg::kffd_ctl_t           ctl
);
  import kffd_pkg::*;

  kffd_state_t          state, state_next;
  logic [StepWidth-1:0] count, count_next;
  logic                 full, full_next;
  logic                 in_fire;
  logic                 out_free;

  assign in_fire   = in_valid && in_ready;
  assign out_free  = !full || out_ready;
  assign out_valid = full;

  // state, step counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      full  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      full  <= full_next;
    end
  end

  // next state and controls
  always_comb begin
    state_next = state;
    count_next = count;
    full_next  = full && !out_ready;
    in_ready   = 1'b0;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          ctl.load   = 1'b1;
          count_next = rot_steps;
          state_next = rot_needed ? ST_ROT : ST_FINISH;
        end
      end
      ST_ROT: begin
        ctl.step   = 1'b1;
        count_next = count - 1'b1;
        if (count == {{(StepWidth-1){1'b0}}, 1'b1}) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait until the result register is free or being taken
        if (out_free) begin
          ctl.latch  = 1'b1;
          full_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

### rtl/core/keyfob_frame_field_decoder.sv
// top level of the key-fob frame field decoder: capture, sequencer, rotate unit, result register
// depends on kffd_pkg, kffd_in_if, kffd_out_if, kffd_rot_unit, kffd_ctrl
//
//  channel    dir  handshake          payload
//  frame_in   in   valid / ready      proto_type, frame_word, extra_word
//  fields_out out  valid / ready      serial_id, button_code, button_present,
//                                     counter_value, counter_present
//
// one item at a time through the rotator: ready only while idle
// type C takes 4 + low count byte rotate steps (4..259) through the one-bit rotator,
// between the accept state and the finish state; other types go from accept straight to finish
// the finished result moves to the output register, which frees the sequencer for the next item
// the finish cycle waits while the output register still holds an untaken result
// rst is synchronous; it clears the sequencer and the result valid only
module keyfob_frame_field_decoder (
  input  logic       clk,
  input  logic       rst,
  kffd_in_if.sink    frame_in,
  kffd_out_if.source fields_out
);
  import kffd_pkg::*;

  proto_t              cap_proto;
  logic [63:0]         cap_word;
  logic [63:0]         cap_extra;
  kffd_ctl_t           ctl;
  logic [RotWidth-1:0] rot_value;
  logic [StepWidth-1:0] rot_steps;
  logic                rot_needed;

  logic [31:0] serial_d;
  logic [3:0]  button_d;
  logic        button_p_d;
  logic [15:0] counter_d;
  logic        counter_p_d;

  // step count and whether the rotator runs
  assign rot_steps  = RotBase + {1'b0, gather_lo(frame_in.frame_word)};
  assign rot_needed = (proto_t'(frame_in.proto_type) == PROTO_C);

  kffd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (frame_in.valid),
    .rot_needed (rot_needed),
    .rot_steps  (rot_steps),
    .out_ready  (fields_out.ready),
    .in_ready   (frame_in.ready),
    .out_valid  (fields_out.valid),
    .ctl        (ctl)
  );

  kffd_rot_unit u_rot (
    .clk   (clk),
    .ctl   (ctl),
    .seed  (rot_seed(frame_in.frame_word)),
    .value (rot_value)
  );

  // capture the item on accept
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cap_proto <= proto_t'(frame_in.proto_type);
      cap_word  <= frame_in.frame_word;
      cap_extra <= frame_in.extra_word;
    end
  end

  // field selection by protocol type
  always_comb begin
    serial_d    = '0;
    button_d    = '0;
    button_p_d  = 1'b0;
    counter_d   = '0;
    counter_p_d = 1'b0;
    unique case (cap_proto)
      PROTO_A: begin
        serial_d    = {4'd0, cap_word[43:16]};
        button_d    = cap_word[15:12];
        button_p_d  = 1'b1;
        counter_d   = cap_word[59:44];
        counter_p_d = 1'b1;
      end
      PROTO_B: begin
        serial_d   = cap_word[31:0];
        button_d   = cap_extra[7:4];
        button_p_d = 1'b1;
      end
      PROTO_C: begin
        serial_d    = {8'd0, cap_word[55:32]};
        button_d    = cap_word[59:56];
        button_p_d  = 1'b1;
        counter_d   = {gather_hi(cap_word, rot_value), gather_lo(cap_word)};
        counter_p_d = 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      fields_out.serial_id       <= serial_d;
      fields_out.button_code     <= button_d;
      fields_out.button_present  <= button_p_d;
      fields_out.counter_value   <= counter_d;
      fields_out.counter_present <= counter_p_d;
    end
  end
endmodule
